FILE: rtl/core/hvd_pkg.sv
`timescale 1ns / 1ps
// hvd_pkg: shared types, codes, constants and saturating arithmetic
// used by hvd_dp, hvd_ctrl and the top of the hmm viterbi decoder; no dependencies

package hvd_pkg;

    localparam int NUM_STATES_DEF  = 8;
    localparam int NUM_SYMBOLS_DEF = 16;
    localparam int MAX_LEN_DEF     = 64;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_SYM  = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;

    localparam logic [1:0] SEL_TRANS = 2'd0;
    localparam logic [1:0] SEL_EMIS  = 2'd1;
    localparam logic [1:0] SEL_INIT  = 2'd2;

    localparam logic signed [15:0] WORD_ZERO = -16'sd32768;
    localparam logic signed [23:0] SCORE_MIN = -24'sd8388608;
    localparam logic signed [23:0] SCORE_MAX = 24'sd8388607;
    localparam logic signed [24:0] SUM_MIN   = -25'sd8388608;
    localparam logic signed [24:0] SUM_MAX   = 25'sd8388607;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ACS,
        S_UPD,
        S_SRCH,
        S_LOAD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic sym_rd;
        logic trans_rd;
        logic acs_en;
        logic init_upd;
        logic acs_upd;
        logic srch_en;
        logic out_load;
        logic out_adv;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_status;

    function automatic logic signed [23:0] add_sat(input logic signed [23:0] score,
                                                  input logic signed [15:0] word);
        logic signed [24:0] s;
        s = 25'(score) + 25'(word);
        if (score == SCORE_MIN || word == WORD_ZERO) begin
            return SCORE_MIN;
        end else if (s < SUM_MIN) begin
            return SCORE_MIN;
        end else if (s > SUM_MAX) begin
            return SCORE_MAX;
        end
        return 24'(s);
    endfunction

endpackage

FILE: rtl/core/hvd_in_if.sv
`timescale 1ns / 1ps
// hvd_in_if: input channel, valid/ready and one input word
// no dependencies

interface hvd_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [1:0]         table_sel;
    logic [2:0]         row;
    logic [3:0]         col;
    logic signed [15:0] log_prob;
    logic [3:0]         symbol;

    modport source (output valid, mode, table_sel, row, col, log_prob, symbol,
                    input ready);
    modport sink (input valid, mode, table_sel, row, col, log_prob, symbol,
                  output ready);
endinterface

FILE: rtl/core/hvd_out_if.sv
`timescale 1ns / 1ps
// hvd_out_if: output channel, valid/ready and one decoded state word
// no dependencies

interface hvd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         state_index;
    logic [5:0]         time_index;
    logic               last;
    logic               overflow;
    logic signed [23:0] best_score;

    modport source (output valid, state_index, time_index, last, overflow, best_score,
                    input ready);
    modport sink (input valid, state_index, time_index, last, overflow, best_score,
                  output ready);
endinterface

FILE: rtl/core/hvd_ram.sv
`timescale 1ns / 1ps
// hvd_ram: generic single write port ram with registered read
// no dependencies

module hvd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/hvd_dp.sv
`timescale 1ns / 1ps
// hvd_dp: datapath with model tables, per-state add-compare-select lanes,
// path scores, backpointer ram, final search and output registers; uses hvd_pkg, hvd_ram

module hvd_dp #(
    parameter int NUM_STATES  = hvd_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = hvd_pkg::NUM_SYMBOLS_DEF,
    parameter int MAX_LEN     = hvd_pkg::MAX_LEN_DEF
) (
    input  logic                             i_clk,
    input  hvd_pkg::t_cmd                    i_cmd,
    input  logic [$clog2(NUM_STATES)-1:0]    i_idx,
    input  logic [$clog2(MAX_LEN+1)-1:0]     i_step,
    input  logic                             i_ovf,
    input  logic [1:0]                       i_table_sel,
    input  logic [2:0]                       i_row,
    input  logic [3:0]                       i_col,
    input  logic signed [15:0]               i_log_prob,
    input  logic [3:0]                       i_symbol,
    output hvd_pkg::t_status                 o_status,
    output logic [2:0]                       o_state_index,
    output logic [5:0]                       o_time_index,
    output logic                             o_last,
    output logic                             o_overflow,
    output logic signed [23:0]               o_best_score
);
    import hvd_pkg::*;

    localparam int SW  = $clog2(NUM_STATES);
    localparam int YW  = $clog2(NUM_SYMBOLS);
    localparam int TW  = $clog2(MAX_LEN);
    localparam int STW = $clog2(MAX_LEN + 1);

    logic               row_ok;
    logic [SW-1:0]      trans_raddr;
    logic               trans_re;
    logic signed [15:0] trans_rdata [NUM_STATES];
    logic signed [15:0] emis_rdata [NUM_STATES];
    logic signed [15:0] emis_eff [NUM_STATES];
    logic signed [15:0] r_init [NUM_STATES];
    logic signed [23:0] r_score [NUM_STATES];
    logic signed [23:0] r_best [NUM_STATES];
    logic [SW-1:0]      r_arg [NUM_STATES];
    logic               r_sym_ok;
    logic signed [23:0] cur_score;
    logic signed [23:0] r_bs;
    logic [SW-1:0]      r_bq;
    logic [SW-1:0]      r_q;
    logic [TW-1:0]      r_t;
    logic               r_oovf;
    logic [NUM_STATES*SW-1:0] bp_wdata;
    logic [NUM_STATES*SW-1:0] bp_rdata;
    logic               bp_re;
    logic [TW-1:0]      bp_raddr;

    assign row_ok      = 32'(i_row) < 32'(NUM_STATES);
    assign trans_re    = i_cmd.sym_rd | i_cmd.trans_rd;
    assign trans_raddr = i_cmd.sym_rd ? '0 : i_idx + SW'(1);
    assign cur_score   = r_score[i_idx];

    for (genvar j = 0; j < NUM_STATES; j++) begin : g_lane
        logic signed [23:0] cand;

        hvd_ram #(.WIDTH(16), .DEPTH(NUM_STATES)) u_trans (
            .i_clk   (i_clk),
            .i_we    (i_cmd.load && i_table_sel == SEL_TRANS && row_ok &&
                      32'(i_col) == j),
            .i_waddr (SW'(i_row)),
            .i_wdata (i_log_prob),
            .i_re    (trans_re),
            .i_raddr (trans_raddr),
            .o_rdata (trans_rdata[j])
        );

        hvd_ram #(.WIDTH(16), .DEPTH(NUM_SYMBOLS)) u_emis (
            .i_clk   (i_clk),
            .i_we    (i_cmd.load && i_table_sel == SEL_EMIS && row_ok &&
                      32'(i_col) < 32'(NUM_SYMBOLS) && 32'(i_row) == j),
            .i_waddr (YW'(i_col)),
            .i_wdata (i_log_prob),
            .i_re    (i_cmd.sym_rd),
            .i_raddr (YW'(i_symbol)),
            .o_rdata (emis_rdata[j])
        );

        assign emis_eff[j] = r_sym_ok ? emis_rdata[j] : WORD_ZERO;
        assign cand = add_sat(cur_score, trans_rdata[j]);
        assign bp_wdata[j*SW +: SW] = r_arg[j];

        always_ff @(posedge i_clk) begin
            if (i_cmd.load && i_table_sel == SEL_INIT && row_ok && 32'(i_row) == j) begin
                r_init[j] <= i_log_prob;
            end
            if (i_cmd.acs_en && (i_idx == '0 || cand > r_best[j])) begin
                r_best[j] <= cand;
                r_arg[j]  <= i_idx;
            end
            if (i_cmd.init_upd) begin
                r_score[j] <= add_sat(24'(r_init[j]), emis_eff[j]);
            end else if (i_cmd.acs_upd) begin
                r_score[j] <= add_sat(r_best[j], emis_eff[j]);
            end
        end
    end

    assign bp_re    = i_cmd.out_load | i_cmd.out_adv;
    assign bp_raddr = i_cmd.out_load ? TW'(i_step - STW'(1)) : r_t - TW'(1);

    hvd_ram #(.WIDTH(NUM_STATES*SW), .DEPTH(MAX_LEN)) u_bp (
        .i_clk   (i_clk),
        .i_we    (i_cmd.acs_upd),
        .i_waddr (TW'(i_step)),
        .i_wdata (bp_wdata),
        .i_re    (bp_re),
        .i_raddr (bp_raddr),
        .o_rdata (bp_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.sym_rd) begin
            r_sym_ok <= 32'(i_symbol) < 32'(NUM_SYMBOLS);
        end
        if (i_cmd.srch_en && (i_idx == '0 || cur_score > r_bs)) begin
            r_bs <= cur_score;
            r_bq <= i_idx;
        end
        if (i_cmd.out_load) begin
            r_q    <= r_bq;
            r_t    <= TW'(i_step - STW'(1));
            r_oovf <= i_ovf;
        end else if (i_cmd.out_adv) begin
            r_q <= bp_rdata[r_q*SW +: SW];
            r_t <= r_t - TW'(1);
        end
    end

    assign o_status.last = (r_t == '0);
    assign o_state_index = 3'(r_q);
    assign o_time_index  = 6'(r_t);
    assign o_last        = (r_t == '0);
    assign o_overflow    = r_oovf;
    assign o_best_score  = r_bs;
endmodule

FILE: rtl/core/hvd_ctrl.sv
`timescale 1ns / 1ps
// hvd_ctrl: sequencing state machine, step count and overflow flag
// uses hvd_pkg; drives the hvd_dp datapath through t_cmd

module hvd_ctrl #(
    parameter int NUM_STATES = hvd_pkg::NUM_STATES_DEF,
    parameter int MAX_LEN    = hvd_pkg::MAX_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [1:0]                    i_mode,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  hvd_pkg::t_status              i_status,
    output hvd_pkg::t_cmd                 o_cmd,
    output logic [$clog2(NUM_STATES)-1:0] o_idx,
    output logic [$clog2(MAX_LEN+1)-1:0]  o_step,
    output logic                          o_ovf
);
    import hvd_pkg::*;

    localparam int SW  = $clog2(NUM_STATES);
    localparam int STW = $clog2(MAX_LEN + 1);

    t_state         r_state, n_state;
    logic [SW-1:0]  r_cnt, n_cnt;
    logic [STW-1:0] r_step, n_step;
    logic           r_ovf, n_ovf;
    logic           r_end, n_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_step  <= '0;
            r_ovf   <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_ovf   <= n_ovf;
            r_end   <= n_end;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_step      = r_step;
        n_ovf       = r_ovf;
        n_end       = r_end;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_mode)
                        MODE_LOAD: o_cmd.load = 1'b1;
                        MODE_SYM, MODE_END: begin
                            n_end = (i_mode == MODE_END);
                            n_cnt = '0;
                            if (r_step < STW'(MAX_LEN)) begin
                                o_cmd.sym_rd = 1'b1;
                                n_state = (r_step == '0) ? S_INIT : S_ACS;
                            end else begin
                                n_ovf = 1'b1;
                                if (i_mode == MODE_END) begin
                                    n_state = S_SRCH;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.init_upd = 1'b1;
                n_step  = r_step + STW'(1);
                n_state = r_end ? S_SRCH : S_IDLE;
            end
            S_ACS: begin
                o_cmd.acs_en = 1'b1;
                if (r_cnt == SW'(NUM_STATES - 1)) begin
                    n_cnt   = '0;
                    n_state = S_UPD;
                end else begin
                    o_cmd.trans_rd = 1'b1;
                    n_cnt = r_cnt + SW'(1);
                end
            end
            S_UPD: begin
                o_cmd.acs_upd = 1'b1;
                n_step  = r_step + STW'(1);
                n_state = r_end ? S_SRCH : S_IDLE;
            end
            S_SRCH: begin
                o_cmd.srch_en = 1'b1;
                if (r_cnt == SW'(NUM_STATES - 1)) begin
                    n_cnt   = '0;
                    n_state = S_LOAD;
                end else begin
                    n_cnt = r_cnt + SW'(1);
                end
            end
            S_LOAD: begin
                o_cmd.out_load = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.last) begin
                        n_step  = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.out_adv = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idx  = r_cnt;
    assign o_step = r_step;
    assign o_ovf  = r_ovf;
endmodule

FILE: rtl/core/hmm_viterbi_decoder.sv
`timescale 1ns / 1ps
// hmm_viterbi_decoder: hidden markov model viterbi decoder, log domain Q8.8
// uses hvd_pkg, hvd_in_if, hvd_out_if, hvd_ctrl, hvd_dp, hvd_ram
//
// usage: words enter on i_in (valid/ready). mode load writes one model word.
// for an observation symbol, one add-compare-select lane per state walks
// all predecessors through the per-lane transition ram, one read per
// cycle; the first symbol of a sequence instead starts from the initial
// scores. a sequence-ending symbol is followed by a search over all states
// for the best final state and a setup state, then one word per time step
// leaves on o_out, last step first, at up to one per cycle from the
// backpointer ram. words on o_out are held while o_out.ready is low; i_in
// is not ready until the last word of the sequence is taken. symbols past
// MAX_LEN are dropped and flag overflow. reset (synchronous, active low)
// clears the step count and overflow flag; model tables hold nothing until
// loaded.

module hmm_viterbi_decoder #(
    parameter int NUM_STATES  = hvd_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = hvd_pkg::NUM_SYMBOLS_DEF,
    parameter int MAX_LEN     = hvd_pkg::MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hvd_in_if.sink     i_in,
    hvd_out_if.source  o_out
);
    import hvd_pkg::*;

    t_cmd                          cmd;
    t_status                       status;
    logic [$clog2(NUM_STATES)-1:0] idx;
    logic [$clog2(MAX_LEN+1)-1:0]  step;
    logic                          ovf;

    hvd_ctrl #(.NUM_STATES(NUM_STATES), .MAX_LEN(MAX_LEN)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_mode      (i_in.mode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_idx       (idx),
        .o_step      (step),
        .o_ovf       (ovf)
    );

    hvd_dp #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .MAX_LEN     (MAX_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_idx         (idx),
        .i_step        (step),
        .i_ovf         (ovf),
        .i_table_sel   (i_in.table_sel),
        .i_row         (i_in.row),
        .i_col         (i_in.col),
        .i_log_prob    (i_in.log_prob),
        .i_symbol      (i_in.symbol),
        .o_status      (status),
        .o_state_index (o_out.state_index),
        .o_time_index  (o_out.time_index),
        .o_last        (o_out.last),
        .o_overflow    (o_out.overflow),
        .o_best_score  (o_out.best_score)
    );
endmodule
